### rtl/fssc_pkg.sv
package fssc_pkg;

   localparam int RecipBits   = 32;
   localparam int ScaleStages = 4;
   localparam int PipeDepth   = 1 + RecipBits + 2 * ScaleStages + 1;

   localparam logic [31:0] RecipAllOnes = 32'hFFFF_FFFF;

   localparam logic [31:0] RstTargetLatency  = 32'd64;
   localparam logic [31:0] RstMinGranularity = 32'd8;
   localparam logic [10:0] RstLatencyCount   = 11'd8;
   localparam logic [31:0] RstUnitWeight     = 32'd1024;

   typedef enum logic [1:0] {
      CSR_TARGET_LATENCY,
      CSR_MIN_GRANULARITY,
      CSR_LATENCY_TASK_COUNT,
      CSR_UNIT_WEIGHT
   } csr_idx_type;

   typedef struct packed {
      logic [10:0] task_count;
      logic [31:0] queue_weight;
      logic [31:0] entity_weight;
      logic        on_queue;
      logic [47:0] run_time;
      logic [47:0] ran_since_pick;
      logic [63:0] curr_vruntime;
      logic [63:0] leftmost_vruntime;
      logic        preemptible;
   } req_type;

   typedef struct packed {
      logic [63:0] time_slice;
      logic [63:0] virtual_slice;
      logic [63:0] vruntime_increase;
      logic        reschedule;
   } rsp_type;

   typedef struct packed {
      logic [31:0] target_latency;
      logic [31:0] min_granularity;
      logic [10:0] latency_task_count;
      logic [31:0] unit_weight;
   } cfg_type;

   typedef struct packed {
      logic [31:0] ew;
      logic [47:0] run;
      logic [47:0] since;
      logic [63:0] curv;
      logic [63:0] leftv;
      logic        preempt;
      logic [10:0] count;
      logic [43:0] period;
   } side_a_type;

   typedef struct packed {
      logic [31:0] ew;
      logic [47:0] run;
      logic [47:0] since;
      logic [63:0] curv;
      logic [63:0] leftv;
      logic        preempt;
      logic [10:0] count;
      logic [31:0] recip_ew;
   } side_b_type;

   typedef struct packed {
      logic [63:0] slice;
      logic [47:0] run;
      logic        unit;
      logic        resched;
   } side_c_type;

endpackage

### rtl/fssc_csr.sv
module fssc_csr import fssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type     cfg_ff;
   csr_idx_type idx;

   assign idx    = csr_idx_type'(paddr[3:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_latency     <= RstTargetLatency;
         cfg_ff.min_granularity    <= RstMinGranularity;
         cfg_ff.latency_task_count <= RstLatencyCount;
         cfg_ff.unit_weight        <= RstUnitWeight;
      end else if (psel && penable && pwrite) begin
         case (idx)
            CSR_TARGET_LATENCY:     cfg_ff.target_latency     <= pwdata;
            CSR_MIN_GRANULARITY:    cfg_ff.min_granularity    <= pwdata;
            CSR_LATENCY_TASK_COUNT: cfg_ff.latency_task_count <= pwdata[10:0];
            CSR_UNIT_WEIGHT:        cfg_ff.unit_weight        <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_TARGET_LATENCY:     prdata = cfg_ff.target_latency;
         CSR_MIN_GRANULARITY:    prdata = cfg_ff.min_granularity;
         CSR_LATENCY_TASK_COUNT: prdata = {21'd0, cfg_ff.latency_task_count};
         CSR_UNIT_WEIGHT:        prdata = cfg_ff.unit_weight;
         default:                prdata = '0;
      endcase
   end

endmodule

### rtl/fssc_delay.sv
module fssc_delay #(
   parameter int W     = 8,
   parameter int Depth = 4
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] data_ff [Depth];

   always_ff @(posedge clock) begin
      data_ff[0] <= din;
      for (int i = 1; i < Depth; i++) data_ff[i] <= data_ff[i-1];
   end

   assign dout = data_ff[Depth-1];

endmodule

### rtl/fssc_recip.sv
module fssc_recip import fssc_pkg::*; (
   input  logic        clock,
   input  logic [32:0] weight,
   output logic [31:0] recip
);

   logic [31:0] rem_ff  [RecipBits];
   logic [31:0] quo_ff  [RecipBits];
   logic [31:0] div_ff  [RecipBits];
   logic        zero_ff [RecipBits];
   logic        big_ff  [RecipBits];

   for (genvar s = 0; s < RecipBits; s++) begin : g_stage
      logic [31:0] rem_in;
      logic [31:0] quo_in;
      logic [31:0] div_in;
      logic        zero_in;
      logic        big_in;
      logic [32:0] trial;
      logic        take;

      if (s == 0) begin : g_first
         assign rem_in  = '0;
         assign quo_in  = '0;
         assign div_in  = weight[31:0];
         assign zero_in = (weight == 33'd0);
         assign big_in  = (weight >= {1'b0, RecipAllOnes});
      end else begin : g_next
         assign rem_in  = rem_ff[s-1];
         assign quo_in  = quo_ff[s-1];
         assign div_in  = div_ff[s-1];
         assign zero_in = zero_ff[s-1];
         assign big_in  = big_ff[s-1];
      end

      assign trial = {rem_in, 1'b1};
      assign take  = (trial >= {1'b0, div_in});

      always_ff @(posedge clock) begin
         rem_ff[s]  <= take ? 32'(trial - {1'b0, div_in}) : trial[31:0];
         quo_ff[s]  <= {quo_in[30:0], take};
         div_ff[s]  <= div_in;
         zero_ff[s] <= zero_in;
         big_ff[s]  <= big_in;
      end
   end

   assign recip = zero_ff[RecipBits-1] ? RecipAllOnes :
                  big_ff[RecipBits-1]  ? 32'd1 : quo_ff[RecipBits-1];

endmodule

### rtl/fssc_scale.sv
module fssc_scale import fssc_pkg::*; (
   input  logic        clock,
   input  logic [63:0] x,
   input  logic [31:0] mul,
   input  logic [31:0] recip,
   output logic [63:0] result
);

   logic [63:0] x1_ff, x2_ff;
   logic [63:0] fac_ff;
   logic [31:0] f2_ff;
   logic [5:0]  sh2_ff, sh3_ff;
   logic [63:0] p0_ff;
   logic [31:0] p1_ff;
   logic [63:0] res_ff;
   logic [5:0]  s;
   logic [63:0] sum;

   always_comb begin
      s = '0;
      for (int i = 0; i < 32; i++) if (fac_ff[32+i]) s = 6'(i + 1);
   end

   assign sum = p0_ff + {p1_ff, 32'd0};

   always_ff @(posedge clock) begin
      fac_ff <= mul * recip;
      x1_ff  <= x;
      f2_ff  <= 32'(fac_ff >> s);
      sh2_ff <= 6'd32 - s;
      x2_ff  <= x1_ff;
      p0_ff  <= x2_ff[31:0] * f2_ff;
      p1_ff  <= 32'(x2_ff[63:32] * f2_ff);
      sh3_ff <= sh2_ff;
      res_ff <= sum >> sh3_ff;
   end

   assign result = res_ff;

endmodule

### rtl/fair_share_slice_calculator.sv
// Fair-share slice calculator: one task's figures in, one scheduling result out.
// Request: drive req_data and pulse start; the beat is taken when busy is low.
// busy stays low, so a new beat may be started every clock cycle.
// Response: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver must take it then, as there is no back-pressure.
// The pipeline is one front stage (period multiply, queue weight sum),
// a 32-stage pipelined reciprocal divider, a 4-stage scaler for the real
// slice, a 4-stage scaler pair for virtual time, and an output register.
// Throughput is one beat per cycle; results leave in request order.
// Configuration: APB port, registers at byte addresses 0 (target latency),
// 4 (min granularity), 8 (latency task count), 12 (unit weight); pready is
// always high. Write only while no beat is in flight.
// Reset (synchronous, active high) restores the register defaults and drops
// every beat in flight.
module fair_share_slice_calculator import fssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type        cfg;
   logic [PipeDepth-1:0] vld_ff;

   side_a_type  side_a_in, side_a_out;
   side_b_type  side_b_in, side_b_out;
   side_c_type  side_c_in, side_c_out;
   logic [32:0] total_ff;
   side_a_type  front_ff;
   logic [11:0] n;
   logic [32:0] total_in;
   logic [31:0] recip_tot, recip_ew;
   logic [63:0] slice, vslice, vrun, d;
   logic        resched;
   rsp_type     rsp_ff;

   fssc_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg
   );

   assign busy = 1'b0;
   assign n    = {1'b0, req_data.task_count} + {11'd0, !req_data.on_queue};
   assign total_in = req_data.on_queue ? {1'b0, req_data.queue_weight} :
                     {1'b0, req_data.queue_weight} + {1'b0, req_data.entity_weight};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[PipeDepth-2:0], start && !busy};
   end

   always_ff @(posedge clock) begin
      total_ff         <= total_in;
      front_ff.ew      <= req_data.entity_weight;
      front_ff.run     <= req_data.run_time;
      front_ff.since   <= req_data.ran_since_pick;
      front_ff.curv    <= req_data.curr_vruntime;
      front_ff.leftv   <= req_data.leftmost_vruntime;
      front_ff.preempt <= req_data.preemptible;
      front_ff.count   <= req_data.task_count;
      front_ff.period  <= (n > {1'b0, cfg.latency_task_count}) ?
                          cfg.min_granularity * n : {12'd0, cfg.target_latency};
   end

   assign side_a_in = front_ff;

   fssc_recip u_recip_tot (.clock, .weight(total_ff), .recip(recip_tot));
   fssc_recip u_recip_ew  (.clock, .weight({1'b0, front_ff.ew}), .recip(recip_ew));

   fssc_delay #(.W($bits(side_a_type)), .Depth(RecipBits)) u_dly_a (
      .clock, .din(side_a_in), .dout(side_a_out)
   );

   fssc_scale u_scale_slice (
      .clock, .x({20'd0, side_a_out.period}), .mul(side_a_out.ew),
      .recip(recip_tot), .result(slice)
   );

   assign side_b_in = '{ew: side_a_out.ew, run: side_a_out.run,
                        since: side_a_out.since, curv: side_a_out.curv,
                        leftv: side_a_out.leftv, preempt: side_a_out.preempt,
                        count: side_a_out.count, recip_ew: recip_ew};

   fssc_delay #(.W($bits(side_b_type)), .Depth(ScaleStages)) u_dly_b (
      .clock, .din(side_b_in), .dout(side_b_out)
   );

   assign d = side_b_out.curv - side_b_out.leftv;

   always_comb begin
      resched = 1'b0;
      if (side_b_out.preempt && side_b_out.count > 11'd1) begin
         if ({16'd0, side_b_out.since} > slice) begin
            resched = 1'b1;
         end else if (side_b_out.since >= {16'd0, cfg.min_granularity}) begin
            resched = !d[63] && (d > slice);
         end
      end
   end

   fssc_scale u_scale_vslice (
      .clock, .x(slice), .mul(cfg.unit_weight), .recip(side_b_out.recip_ew),
      .result(vslice)
   );

   fssc_scale u_scale_vrun (
      .clock, .x({16'd0, side_b_out.run}), .mul(cfg.unit_weight),
      .recip(side_b_out.recip_ew), .result(vrun)
   );

   assign side_c_in = '{slice: slice, run: side_b_out.run,
                        unit: (side_b_out.ew == cfg.unit_weight), resched: resched};

   fssc_delay #(.W($bits(side_c_type)), .Depth(ScaleStages)) u_dly_c (
      .clock, .din(side_c_in), .dout(side_c_out)
   );

   always_ff @(posedge clock) begin
      rsp_ff.time_slice        <= side_c_out.slice;
      rsp_ff.virtual_slice     <= side_c_out.unit ? side_c_out.slice : vslice;
      rsp_ff.vruntime_increase <= side_c_out.unit ? {16'd0, side_c_out.run} : vrun;
      rsp_ff.reschedule        <= side_c_out.resched;
   end

   assign rsp_valid = vld_ff[PipeDepth-1];
   assign rsp_data  = rsp_ff;

endmodule

### test/tb.sv
module tb;
   import fssc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxCycles = 600000;
   localparam int DrainCycles = 60;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type e;
   } row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [31:0] tgt_latency;
   logic [31:0] min_gran;
   logic [10:0] lat_count;
   logic [31:0] unit_wt;

   rsp_type pending_slices[$];
   int      errors = 0;
   int      cycles = 0;
   bit      idle_free;
   row_type rows[$];

   fair_share_slice_calculator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MaxCycles) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [63:0] weight_recip(logic [63:0] w);
      if (w >= 64'hFFFF_FFFF) return 64'd1;
      if (w == 64'd0) return 64'hFFFF_FFFF;
      return 64'hFFFF_FFFF / w;
   endfunction

   function automatic logic [63:0] scale_by(logic [63:0] x, logic [31:0] mul,
                                            logic [63:0] dvs);
      logic [63:0] factor;
      logic [63:0] prod;
      int          shift;
      factor = {32'd0, mul} * weight_recip(dvs);
      shift = 32;
      while (factor[63:32] != 32'd0) begin
         factor = factor >> 1;
         shift--;
      end
      prod = x * factor;
      return prod >> shift;
   endfunction

   function automatic logic [63:0] to_virtual(logic [63:0] t, logic [31:0] ew);
      if (ew != unit_wt) return scale_by(t, unit_wt, {32'd0, ew});
      return t;
   endfunction

   function automatic rsp_type fair_slice(req_type r);
      rsp_type     o;
      logic [63:0] n;
      logic [63:0] period;
      logic [63:0] total;
      logic [63:0] d;
      n = {53'd0, r.task_count} + (r.on_queue ? 64'd0 : 64'd1);
      period = {32'd0, tgt_latency};
      if (n > {53'd0, lat_count}) period = {32'd0, min_gran} * n;
      total = r.on_queue ? {32'd0, r.queue_weight}
                         : {32'd0, r.queue_weight} + {32'd0, r.entity_weight};
      o.time_slice = scale_by(period, r.entity_weight, total);
      o.virtual_slice = to_virtual(o.time_slice, r.entity_weight);
      o.vruntime_increase = to_virtual({16'd0, r.run_time}, r.entity_weight);
      o.reschedule = 1'b0;
      if (r.preemptible && r.task_count > 11'd1) begin
         if ({16'd0, r.ran_since_pick} > o.time_slice) begin
            o.reschedule = 1'b1;
         end else if ({16'd0, r.ran_since_pick} >= {32'd0, min_gran}) begin
            d = r.curr_vruntime - r.leftmost_vruntime;
            if (!d[63] && d > o.time_slice) o.reschedule = 1'b1;
         end
      end
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_slices.size() == 0) begin
            report("unexpected beat", rsp_data.time_slice, 64'd0);
         end else begin
            want = pending_slices.pop_front();
            if (rsp_data.time_slice !== want.time_slice)
               report("time_slice", rsp_data.time_slice, want.time_slice);
            if (rsp_data.virtual_slice !== want.virtual_slice)
               report("virtual_slice", rsp_data.virtual_slice, want.virtual_slice);
            if (rsp_data.vruntime_increase !== want.vruntime_increase)
               report("vruntime_increase", rsp_data.vruntime_increase,
                      want.vruntime_increase);
            if (rsp_data.reschedule !== want.reschedule)
               report("reschedule", {63'd0, rsp_data.reschedule},
                      {63'd0, want.reschedule});
         end
      end
   end

   task automatic send(req_type r, rsp_type want);
      int pick;
      int gap;
      req_data <= r;
      start <= 1'b1;
      forever begin
         @(negedge clock);
         if (!busy) begin
            pending_slices.push_back(want);
            @(posedge clock);
            break;
         end
         @(posedge clock);
      end
      pick = $urandom_range(0, 99);
      gap = idle_free ? 0 : (pick < 50 ? 0 : pick < 90 ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(csr_idx_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 4'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         CSR_TARGET_LATENCY:     tgt_latency = value;
         CSR_MIN_GRANULARITY:    min_gran = value;
         CSR_LATENCY_TASK_COUNT: lat_count = value[10:0];
         CSR_UNIT_WEIGHT:        unit_wt = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_slices.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] tl, logic [31:0] mg, logic [10:0] lc,
                            logic [31:0] uw);
      drain();
      csr_write(CSR_TARGET_LATENCY, tl);
      csr_write(CSR_MIN_GRANULARITY, mg);
      csr_write(CSR_LATENCY_TASK_COUNT, {21'd0, lc});
      csr_write(CSR_UNIT_WEIGHT, uw);
   endtask

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3: return unit_wt;
         4: return $urandom_range(1, 4096);
         5: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [47:0] pick_time();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0] >> $urandom_range(0, 47);
   endfunction

   function automatic req_type random_req();
      req_type     r;
      rsp_type     o;
      logic [63:0] s;
      logic [63:0] delta;
      r.task_count = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 1024))
                                               : 11'($urandom_range(0, 20));
      if ($urandom_range(0, 15) == 0) r.task_count = 11'd1024;
      r.queue_weight = pick_weight();
      r.entity_weight = pick_weight();
      r.on_queue = 1'($urandom_range(0, 1));
      r.run_time = pick_time();
      r.preemptible = $urandom_range(0, 4) != 0;
      r.ran_since_pick = 48'd0;
      o = fair_slice(r);
      s = o.time_slice + 64'($signed($urandom_range(0, 8)) - 4);
      case ($urandom_range(0, 3))
         0: r.ran_since_pick = s[47:0];
         1: r.ran_since_pick = 48'(min_gran) + 48'($urandom_range(0, 2)) - 48'd1;
         default: r.ran_since_pick = pick_time();
      endcase
      r.leftmost_vruntime = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: delta = {$urandom, $urandom};
         1: delta = -64'($urandom_range(0, 1000));
         default: delta = o.time_slice + 64'($signed($urandom_range(0, 8)) - 4);
      endcase
      r.curr_vruntime = r.leftmost_vruntime + delta;
      return r;
   endfunction

   task automatic random_run(int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) idle_free = $urandom_range(0, 3) == 0;
         r = random_req();
         send(r, fair_slice(r));
      end
      idle_free = 1'b0;
   endtask

   function automatic req_type mk(logic [10:0] cnt, logic [31:0] qw, logic [31:0] ew,
                                  logic onq, logic [47:0] run, logic [47:0] since,
                                  logic [63:0] cv, logic [63:0] lv, logic pre);
      req_type r;
      r.task_count = cnt;
      r.queue_weight = qw;
      r.entity_weight = ew;
      r.on_queue = onq;
      r.run_time = run;
      r.ran_since_pick = since;
      r.curr_vruntime = cv;
      r.leftmost_vruntime = lv;
      r.preemptible = pre;
      return r;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type e);
      row_type w;
      w.r = r;
      w.typed = typed;
      w.e = e;
      rows.push_back(w);
   endfunction

   initial begin
      rsp_type none;
      rsp_type want;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      idle_free = 1'b0;
      tgt_latency = RstTargetLatency;
      min_gran = RstMinGranularity;
      lat_count = RstLatencyCount;
      unit_wt = RstUnitWeight;
      none = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{64'd0, 64'd0, 64'd0, 1'b0});
      add_row(mk(0, 0, 1024, 0, 100, 0, 0, 0, 0), 1, '{64'd63, 64'd63, 64'd100, 1'b0});
      add_row(mk(1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 48'hFFFF_FFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, '1, '1, 1), 0, none);
      add_row(mk(1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 48'hFFFF_FFFF_FFFF, 0,
                 '1, 0, 1), 0, none);
      add_row(mk(8, 4096, 1024, 1, 500, 0, 0, 0, 0), 0, none);
      add_row(mk(8, 4096, 1024, 0, 500, 0, 0, 0, 0), 0, none);
      add_row(mk(9, 4096, 2048, 1, 12345, 0, 0, 0, 0), 0, none);
      add_row(mk(4, 4096, 1024, 1, 0, 48'd1000, 0, 0, 1), 0, none);
      add_row(mk(4, 4096, 1024, 1, 0, 48'd8, 64'd1000, 64'd0, 1), 0, none);
      add_row(mk(4, 4096, 1024, 1, 0, 48'd8, 64'd0, 64'd1, 1), 0, none);
      add_row(mk(4, 4096, 1024, 1, 0, 48'd7, 64'd1000, 64'd0, 1), 0, none);
      add_row(mk(1, 4096, 1024, 1, 0, 48'd1000, 64'd1000, 64'd0, 1), 0, none);
      add_row(mk(2, 4096, 1024, 1, 0, 48'd1000, 64'd1000, 64'd0, 0), 0, none);
      add_row(mk(3, 0, 32'hFFFF_FFFF, 0, 48'd77, 0, 0, 0, 0), 0, none);
      add_row(mk(3, 32'h8000_0000, 32'h8000_0000, 0, 48'd77, 0, 0, 0, 0), 0, none);
      add_row(mk(1023, 1, 1, 1, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0), 0, none);
      foreach (rows[i]) begin
         want = rows[i].typed ? rows[i].e : fair_slice(rows[i].r);
         send(rows[i].r, want);
      end
      random_run(300);

      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1024, 32'hFFFF_FFFF);
      random_run(300);
      configure(32'd1, 32'd1, 11'd1, 32'd1);
      random_run(300);
      configure($urandom, $urandom_range(1, 100000), 11'($urandom_range(1, 1024)),
                $urandom_range(1, 1 << 20));
      random_run(300);
      configure($urandom_range(1, 1000000), $urandom_range(1, 1000),
                11'($urandom_range(1, 32)), $urandom);
      random_run(300);
      configure(32'd6000000, 32'd750000, 11'd8, 32'd1024);
      random_run(300);

      drain();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

### fair_share_slice_calculator.f
rtl/fssc_pkg.sv
rtl/fssc_csr.sv
rtl/fssc_delay.sv
rtl/fssc_recip.sv
rtl/fssc_scale.sv
rtl/fair_share_slice_calculator.sv
test/tb.sv
